[hdl/sfd_pkg.sv]
`default_nettype none

package sfd_pkg;

  // Frame layout: two start bytes, twelve payload bytes, one checksum byte
  localparam int unsigned POS_W       = 4;
  localparam int unsigned BODY_FIRST  = 2;
  localparam int unsigned BODY_LAST   = 13;
  localparam int unsigned BODY_BYTES  = BODY_LAST - BODY_FIRST + 1;
  localparam int unsigned RESULT_W    = 8 * BODY_BYTES;
  localparam logic [POS_W-1:0] CHECK_POS = POS_W'(14);

  // Configuration register indexes
  localparam logic CFG_FIRST_SYNC  = 1'b0;
  localparam logic CFG_SECOND_SYNC = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_SYNC1 = 2'd1,
    PH_BODY  = 2'd2
  } phase_t;

  // Frame check outcome handed from the parser to the output stage
  typedef struct packed {
    logic                ok;
    logic [RESULT_W-1:0] data;
  } frame_result_t;

endpackage

`default_nettype wire

[hdl/sfd_parser.sv]
`default_nettype none

module sfd_parser (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  take,
  input  wire logic [7:0]            rx_byte,
  input  wire logic [7:0]            first_sync,
  input  wire logic [7:0]            second_sync,
  output sfd_pkg::frame_result_t     result
);
  import sfd_pkg::*;

  phase_t           phase;
  phase_t           phase_next;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [7:0]       sum;
  logic [7:0]       sum_next;
  logic             body_store;
  logic             frame_good;
  logic [7:0]       body [BODY_FIRST:BODY_LAST];

  always_comb begin
    phase_next = phase;
    if (take) begin
      unique case (phase)
        PH_SYNC1: begin
          if (rx_byte == second_sync) begin
            phase_next = PH_BODY;
          end else if (rx_byte == first_sync) begin
            phase_next = PH_SYNC1;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_BODY: begin
          if (pos == CHECK_POS) begin
            phase_next = PH_HUNT;
          end
        end
        default: begin
          phase_next = (rx_byte == first_sync) ? PH_SYNC1 : PH_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    pos_next   = pos;
    sum_next   = sum;
    body_store = 1'b0;
    frame_good = 1'b0;
    if (take) begin
      unique case (phase)
        PH_SYNC1: begin
          if (rx_byte == second_sync) begin
            pos_next = pos + POS_W'(1);
            sum_next = sum + rx_byte;
          end else if (rx_byte == first_sync) begin
            // restart on a repeated first start byte
            pos_next = POS_W'(1);
            sum_next = rx_byte;
          end else begin
            pos_next = '0;
            sum_next = '0;
          end
        end
        PH_BODY: begin
          if (pos == CHECK_POS) begin
            frame_good = (rx_byte == sum);
            pos_next   = '0;
            sum_next   = '0;
          end else begin
            body_store = 1'b1;
            pos_next   = pos + POS_W'(1);
            sum_next   = sum + rx_byte;
          end
        end
        default: begin
          if (rx_byte == first_sync) begin
            pos_next = POS_W'(1);
            sum_next = rx_byte;
          end else begin
            pos_next = '0;
            sum_next = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      pos   <= '0;
      sum   <= '0;
    end else begin
      phase <= phase_next;
      pos   <= pos_next;
      sum   <= sum_next;
    end
  end

  // Payload bytes land at their frame position; start bytes are never read
  for (genvar i = BODY_FIRST; i <= BODY_LAST; i++) begin : g_body
    always_ff @(posedge clk) begin
      if (body_store && (pos == POS_W'(i))) begin
        body[i] <= rx_byte;
      end
    end
    assign result.data[8*(i-BODY_FIRST) +: 8] = body[i];
  end

  assign result.ok = frame_good;

  a_hunt_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT) |-> (pos == '0) && (sum == '0))
    else $error("hunt phase with stale position or sum");

  a_sync1_pos: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SYNC1) |-> (pos == POS_W'(1)))
    else $error("first start byte seen but position is not one");

  a_body_pos: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (pos >= POS_W'(BODY_FIRST)) && (pos <= CHECK_POS))
    else $error("body position out of frame");

  a_good_at_check: assert property (@(posedge clk) disable iff (rst)
    result.ok |-> take && (phase == PH_BODY) && (pos == CHECK_POS))
    else $error("frame accepted away from the checksum byte");

  a_good_ends_frame: assert property (@(posedge clk) disable iff (rst)
    result.ok |=> (phase == PH_HUNT))
    else $error("hunting did not resume after a good frame");

endmodule

`default_nettype wire

[hdl/status_frame_deframer_unit.sv]
`default_nettype none

// Channel  | Dir | Handshake          | Payload
// s_       | in  | s_tvalid/s_tready  | s_tdata: rx_byte
// m_       | out | m_tvalid/m_tready  | m_tdata: decoded status frame
// cfg_     | in  | cfg_we             | cfg_index, cfg_data: start byte values
//
// One received byte per cycle while s_tready is high; each byte updates the hunt
// state in the cycle it is accepted. A good frame shows on m_ the cycle after its
// checksum byte. The output register lets s_ run on while m_tready is high, and
// s_tready drops only while a result is held and m_tready is low.
// Reset (rst, synchronous) clears both start bytes to zero and returns to hunting.
module status_frame_deframer_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [7:0]                   s_tdata,   // [7:0] rx_byte
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // [7:0] command_result, [15:8] linear_speed, [23:16] angular_speed,
  // [31:24] obstacle, [39:32] error_code, [47:40] motion_status,
  // [55:48] message_id, [87:56] travelled_distance, [95:88] reserved_byte
  output logic [sfd_pkg::RESULT_W-1:0]      m_tdata,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [7:0]                   cfg_data
);
  import sfd_pkg::*;

  logic          take;
  logic [7:0]    first_sync;
  logic [7:0]    second_sync;
  frame_result_t result;

  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sync  <= '0;
      second_sync <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_SYNC:  first_sync  <= cfg_data;
        CFG_SECOND_SYNC: second_sync <= cfg_data;
        default:         ;
      endcase
    end
  end

  sfd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .rx_byte     (s_tdata),
    .first_sync  (first_sync),
    .second_sync (second_sync),
    .result      (result)
  );

  // Hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (result.ok) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.ok) begin
      m_tdata <= result.data;
    end
  end

endmodule

`default_nettype wire
